// ===== sv/ttwm_pkg.sv =====
// ============================================================================
// ttwm_pkg: shared types and constants of the task to worker mapper
// Field widths, register indexes, mode codes, controller states and the
// least-loaded comparator node used by the datapath.
// ============================================================================
`default_nettype none

package ttwm_pkg;

    localparam int WORKERS    = 16;
    localparam int IDX_BITS   = 4;
    localparam int COUNT_BITS = 5;
    localparam int LOAD_BITS  = 40;
    localparam int DUR_BITS   = 32;
    localparam int TASK_BITS  = 16;
    localparam int MODE_BITS  = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_MAPPING_MODE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WORKER_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TASK_TOTAL   = 2'd2;

    // Mapping modes. The unused code behaves as dynamic mode.
    localparam logic [MODE_BITS-1:0] MODE_DYNAMIC = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_CYCLIC  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_BLOCK   = 2'd2;

    localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};
    localparam logic [TASK_BITS-1:0] TASK_MAX = {TASK_BITS{1'b1}};

    typedef struct packed {
        logic [DUR_BITS-1:0] duration;
        logic                restart;
    } task_req_t;

    typedef struct packed {
        logic [IDX_BITS-1:0]  worker_index;
        logic [LOAD_BITS-1:0] worker_load;
        logic [LOAD_BITS-1:0] peak_load;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TREE,
        S_APPLY,
        S_LOAD,
        S_DIV
    } state_t;

    typedef struct packed {
        logic capture;
        logic tree_load;
        logic apply;
        logic div_load;
    } mapper_cmd_t;

    typedef struct packed {
        logic div_done;
    } mapper_status_t;

    typedef struct packed {
        logic                 valid;
        logic [IDX_BITS-1:0]  idx;
        logic [LOAD_BITS-1:0] load;
    } node_t;

    // Pick the smaller load of two nodes; on a tie the higher-index node wins.
    function automatic node_t combine_nodes(input node_t lo, input node_t hi);
        node_t r;
        if (!hi.valid) begin
            r = lo;
        end else if (!lo.valid) begin
            r = hi;
        end else if (hi.load <= lo.load) begin
            r = hi;
        end else begin
            r = lo;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ttwm_div.sv =====
// ============================================================================
// ttwm_div: restoring divider for the block size
// Divides the task total by the active worker count, one quotient bit per
// cycle, and keeps the quotient and remainder until the next load.
// ============================================================================
`default_nettype none

module ttwm_div
    import ttwm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic [TASK_BITS-1:0]  dividend,
    input  wire logic [COUNT_BITS-1:0] divisor,
    output logic      [TASK_BITS-1:0]  quotient,
    output logic      [COUNT_BITS-1:0] remainder,
    output logic                       done
);

    logic [TASK_BITS-1:0]  quo_reg, quo_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS:0]   trial;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[TASK_BITS-1]};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = COUNT_BITS'(TASK_BITS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = COUNT_BITS'(trial - {1'b0, divisor});
                quo_next = {quo_reg[TASK_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[COUNT_BITS-1:0];
                quo_next = {quo_reg[TASK_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Reset leaves 0 / 16, which matches the register reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = (cnt_reg == '0);

endmodule

`default_nettype wire

// ===== sv/ttwm_datapath.sv =====
// ============================================================================
// ttwm_datapath: loads, counters, selection logic and result register
// Holds the configuration registers and per-worker loads, runs the
// least-loaded comparator tree in the tree and apply states and applies each request.
// ============================================================================
`default_nettype none

module ttwm_datapath
    import ttwm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    input  wire task_req_t                task_req,
    input  wire mapper_cmd_t              cmd,
    output mapper_status_t                status,
    output result_t                       result
);

    logic [MODE_BITS-1:0]  mode_reg;
    logic [COUNT_BITS-1:0] wcount_reg;
    logic [TASK_BITS-1:0]  total_reg;

    task_req_t             in_reg;
    logic [LOAD_BITS-1:0]  loads_reg [WORKERS];
    logic [TASK_BITS-1:0]  ts_reg, ts_next;
    logic [IDX_BITS-1:0]   ptr_reg, ptr_next;
    logic [IDX_BITS-1:0]   bw_reg, bw_next;
    logic [TASK_BITS-1:0]  fill_reg, fill_next;
    logic [LOAD_BITS-1:0]  max_reg, max_next;
    node_t                 node_reg [4];
    result_t               result_reg;

    logic [COUNT_BITS-1:0] n_act;
    logic [TASK_BITS-1:0]  base;
    logic [COUNT_BITS-1:0] rem;
    logic                  div_done;

    node_t                 leaf [WORKERS];
    node_t                 lvl1 [8];
    node_t                 lvl2 [4];
    node_t                 lvl3 [2];
    node_t                 best;

    logic [TASK_BITS-1:0]  e_ts, e_fill, fill0;
    logic [IDX_BITS-1:0]   e_ptr, e_bw, bw0, nb;
    logic [LOAD_BITS-1:0]  e_max, e_load;
    logic [TASK_BITS:0]    bsize;
    logic [IDX_BITS-1:0]   w;
    logic [LOAD_BITS:0]    sum_wide;
    logic [LOAD_BITS-1:0]  sum;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DYNAMIC;
            wcount_reg <= COUNT_BITS'(WORKERS);
            total_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAPPING_MODE: mode_reg   <= cfg_data[MODE_BITS-1:0];
                REG_WORKER_COUNT: wcount_reg <= cfg_data[COUNT_BITS-1:0];
                REG_TASK_TOTAL:   total_reg  <= cfg_data[TASK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (wcount_reg == '0)
        begin
            n_act = COUNT_BITS'(1);
        end
        else if (wcount_reg > COUNT_BITS'(WORKERS))
        begin
            n_act = COUNT_BITS'(WORKERS);
        end
        else
        begin
            n_act = wcount_reg;
        end
    end

    ttwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cmd.div_load),
        .dividend  (total_reg),
        .divisor   (n_act),
        .quotient  (base),
        .remainder (rem),
        .done      (div_done)
    );

    assign status.div_done = div_done;

    // Comparator tree; the first two levels are registered in the tree cycle.
    always_comb
    begin
        for (int i = 0; i < WORKERS; i++)
        begin
            leaf[i].valid = (COUNT_BITS'(i) < n_act);
            leaf[i].idx   = IDX_BITS'(i);
            leaf[i].load  = loads_reg[i];
        end
        for (int j = 0; j < 8; j++)
        begin
            lvl1[j] = combine_nodes(leaf[2*j], leaf[2*j+1]);
        end
        for (int k = 0; k < 4; k++)
        begin
            lvl2[k] = combine_nodes(lvl1[2*k], lvl1[2*k+1]);
        end
        lvl3[0] = combine_nodes(node_reg[0], node_reg[1]);
        lvl3[1] = combine_nodes(node_reg[2], node_reg[3]);
        best    = combine_nodes(lvl3[0], lvl3[1]);
    end

    // Selection and update for the captured request.
    always_comb
    begin
        e_ts   = in_reg.restart ? '0 : ts_reg;
        e_ptr  = in_reg.restart ? '0 : ptr_reg;
        e_bw   = in_reg.restart ? '0 : bw_reg;
        e_fill = in_reg.restart ? '0 : fill_reg;
        e_max  = in_reg.restart ? '0 : max_reg;

        ptr_next  = ptr_reg;
        bw_next   = bw_reg;
        fill_next = fill_reg;
        if (in_reg.restart)
        begin
            ptr_next  = '0;
            bw_next   = '0;
            fill_next = '0;
        end

        // Block mode: at most one step forward, then skip any empty blocks.
        bw0   = ({1'b0, e_bw} >= n_act) ? IDX_BITS'(n_act - 1'b1) : e_bw;
        bsize = {1'b0, base} + ((COUNT_BITS'(bw0) < rem) ? 1'b1 : 1'b0);
        nb    = bw0;
        fill0 = e_fill;
        if ((COUNT_BITS'(bw0) + 1'b1 < n_act) && ({1'b0, e_fill} >= bsize))
        begin
            nb    = bw0 + 1'b1;
            fill0 = '0;
            if ((base == '0) && (COUNT_BITS'(nb) >= rem))
            begin
                nb = IDX_BITS'(n_act - 1'b1);
            end
        end

        case (mode_reg)
            MODE_CYCLIC:
            begin
                w        = ({1'b0, e_ptr} >= n_act) ? '0 : e_ptr;
                ptr_next = (COUNT_BITS'(w) + 1'b1 >= n_act) ? '0 : w + 1'b1;
            end
            MODE_BLOCK:
            begin
                w         = nb;
                bw_next   = nb;
                fill_next = (fill0 < TASK_MAX) ? fill0 + 1'b1 : fill0;
            end
            default:
            begin
                if (e_ts < TASK_BITS'(n_act))
                begin
                    w = e_ts[IDX_BITS-1:0];
                end
                else
                begin
                    w = best.idx;
                end
            end
        endcase

        ts_next  = (e_ts < TASK_MAX) ? e_ts + 1'b1 : e_ts;
        e_load   = in_reg.restart ? '0 : loads_reg[w];
        sum_wide = {1'b0, e_load} + (LOAD_BITS+1)'(in_reg.duration);
        sum      = sum_wide[LOAD_BITS] ? LOAD_MAX : sum_wide[LOAD_BITS-1:0];
        max_next = (sum > e_max) ? sum : e_max;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= task_req;
        end
        if (cmd.tree_load)
        begin
            for (int k = 0; k < 4; k++)
            begin
                node_reg[k] <= lvl2[k];
            end
        end
        if (cmd.apply)
        begin
            result_reg.worker_index <= w;
            result_reg.worker_load  <= sum;
            result_reg.peak_load    <= max_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORKERS; i++)
            begin
                loads_reg[i] <= '0;
            end
            ts_reg   <= '0;
            ptr_reg  <= '0;
            bw_reg   <= '0;
            fill_reg <= '0;
            max_reg  <= '0;
        end
        else if (cmd.apply)
        begin
            for (int i = 0; i < WORKERS; i++)
            begin
                if (IDX_BITS'(i) == w)
                begin
                    loads_reg[i] <= sum;
                end
                else if (in_reg.restart)
                begin
                    loads_reg[i] <= '0;
                end
            end
            ts_reg   <= ts_next;
            ptr_reg  <= ptr_next;
            bw_reg   <= bw_next;
            fill_reg <= fill_next;
            max_reg  <= max_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sv/ttwm_ctrl.sv =====
// ============================================================================
// ttwm_ctrl: request sequencer of the task to worker mapper
// Steps each request through capture, tree and apply, owns the result valid
// flag and holds requests off while the block size is being recomputed.
// ============================================================================
`default_nettype none

module ttwm_ctrl
    import ttwm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           task_valid,
    output logic                task_ready,
    output logic                result_valid,
    input  wire logic           result_ready,
    input  wire logic           cfg_we,
    input  wire mapper_status_t status,
    output mapper_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (task_valid)
                begin
                    state_next = S_TREE;
                end
                else if (cfg_we)
                begin
                    state_next = S_LOAD;
                end
            end
            S_TREE:  state_next = S_APPLY;
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:  state_next = cfg_we ? S_LOAD : S_DIV;
            S_DIV:
            begin
                if (cfg_we)
                begin
                    state_next = S_LOAD;
                end
                else if (status.div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        task_ready    = (state_reg == S_IDLE);
        cmd.capture   = (state_reg == S_IDLE) && task_valid;
        cmd.tree_load = (state_reg == S_TREE);
        cmd.apply     = (state_reg == S_APPLY) && out_free;
        cmd.div_load  = (state_reg == S_LOAD);
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

    // A new result only ever appears out of the apply cycle.
    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result valid rose without an apply cycle");

    // An accepted request always moves on to the tree cycle.
    a_accept_to_tree: assert property (@(posedge clk) disable iff (!rst_n)
        (task_valid && task_ready) |=> (state_reg == S_TREE))
        else $error("accepted request did not enter the tree cycle");

    // No request is taken while the block size is being recomputed.
    a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD || state_reg == S_DIV) |-> !task_ready)
        else $error("request accepted during the block size division");

    // Apply never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> (!out_valid_reg || result_ready))
        else $error("apply overwrote a pending result");

endmodule

`default_nettype wire

// ===== sv/task_to_worker_mapper.sv =====
// ============================================================================
// task_to_worker_mapper: greedy least-loaded task scheduler
// Assigns each task duration to one of up to sixteen workers in dynamic
// least-loaded, cyclic or block mode and reports the new and peak loads.
// ============================================================================
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   -----------------------------------
//   task      task_valid / task_ready   task_req  (duration, restart)
//   result    result_valid / result_r.  result    (worker_index, loads)
//   config    cfg_we                    cfg_index, cfg_data
//
// A request is accepted when idle; the tree state registers the first two
// levels of the sixteen-way comparator tree, and the apply state finishes the
// tree, adds the duration and updates the loads; no new request is taken
// until the last one is applied. A configuration write while idle with no
// request offered, or during a recompute, starts a recompute of the block
// size in a bit-serial divider, during which no request is taken. After reset
// all loads and counters are zero and the registers hold their reset values.
// A stalled result only holds the apply cycle once the next request has been taken.
`default_nettype none

module task_to_worker_mapper
    import ttwm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     task_valid,
    output logic                          task_ready,
    input  wire task_req_t                task_req,
    output logic                          result_valid,
    input  wire logic                     result_ready,
    output result_t                       result,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Commands flow from the sequencer to the datapath; the datapath only
    // reports back when the block size division has finished.
    mapper_cmd_t    cmd;
    mapper_status_t status;

    ttwm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_ready   (task_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cfg_we       (cfg_we),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath keeps the configuration registers, the per-worker loads,
    // the mode counters and the result register that parts the two sides.
    ttwm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .task_req  (task_req),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== tb/task_to_worker_mapper_test.sv =====
// ============================================================================
// task_to_worker_mapper_test: self-checking bench for the task mapper
// Drives task requests through the valid/ready channel, predicts the chosen
// worker, its new load and the peak load for every accepted request, and
// compares each result in order. Covers all mapping modes, register edge
// values, saturation, restarts, back-pressure and random idling.
// ============================================================================
module task_to_worker_mapper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ttwm_pkg::*;

    // The fourth mode code is not named by the package; it behaves as dynamic.
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 32;
    localparam int LONG_HOLD    = 400;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     task_valid   = 1'b0;
    logic                     task_ready;
    task_req_t                task_req     = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    result_t                  result;
    logic                     cfg_we       = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

    // Predicted schedule state, mirroring what the block keeps internally.
    logic [LOAD_BITS-1:0]  sched_loads [WORKERS];
    logic [TASK_BITS-1:0]  sched_tasks_seen;
    logic [IDX_BITS-1:0]   sched_cyclic_ptr;
    logic [IDX_BITS-1:0]   sched_block_worker;
    logic [TASK_BITS-1:0]  sched_block_fill;
    logic [LOAD_BITS-1:0]  sched_peak;

    // Register copies, updated on the edge at which the write lands.
    logic [MODE_BITS-1:0]  cfg_mode;
    logic [COUNT_BITS-1:0] cfg_workers;
    logic [TASK_BITS-1:0]  cfg_total;

    // Expected results, oldest first.
    result_t pending_assignments [$];

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  cycle_count   = 0;
    bit  sender_idles  = 1'b0;
    bit  receiver_idles = 1'b0;
    int  hold_left     = 0;
    int  stall_left    = 0;

    task_to_worker_mapper uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_ready   (task_ready),
        .task_req     (task_req),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Schedule predictor
    // ------------------------------------------------------------------------

    // A restart and a reset both wipe every load and counter; the registers
    // are left alone.
    task automatic clear_schedule();
        int i;
        for (i = 0; i < WORKERS; i++)
        begin
            sched_loads[i] = '0;
        end
        sched_tasks_seen   = '0;
        sched_cyclic_ptr   = '0;
        sched_block_worker = '0;
        sched_block_fill   = '0;
        sched_peak         = '0;
    endtask

    // Works out which worker takes the request and what the loads become.
    task automatic assign_task(input task_req_t req, output result_t res);
        int n;
        int w;
        int i;
        int base;
        int extra;
        int span;
        logic [LOAD_BITS:0] sum;

        // A worker count of zero acts as one worker, and anything above the
        // number of physical workers is clamped.
        if (cfg_workers == 0)
            n = 1;
        else if (cfg_workers > WORKERS)
            n = WORKERS;
        else
            n = int'(cfg_workers);

        if (req.restart)
            clear_schedule();

        if (cfg_mode == MODE_CYCLIC)
        begin
            // A pointer left beyond a shrunken worker count wraps to zero.
            if (sched_cyclic_ptr >= n)
                sched_cyclic_ptr = '0;
            w = int'(sched_cyclic_ptr);
            sched_cyclic_ptr = (w + 1 >= n) ? '0 : IDX_BITS'(w + 1);
        end
        else if (cfg_mode == MODE_BLOCK)
        begin
            // Block sizes are floor(T/N), with one extra for the first T mod N
            // workers. Empty blocks are skipped, and the last worker soaks up
            // everything past the total.
            base  = int'(cfg_total) / n;
            extra = int'(cfg_total) % n;
            if (sched_block_worker >= n)
                sched_block_worker = IDX_BITS'(n - 1);
            span = base + ((int'(sched_block_worker) < extra) ? 1 : 0);
            while (int'(sched_block_worker) + 1 < n && int'(sched_block_fill) >= span)
            begin
                sched_block_worker = sched_block_worker + 1'b1;
                sched_block_fill   = '0;
                span = base + ((int'(sched_block_worker) < extra) ? 1 : 0);
            end
            w = int'(sched_block_worker);
            if (sched_block_fill != TASK_MAX)
                sched_block_fill = sched_block_fill + 1'b1;
        end
        else
        begin
            // Dynamic mode (and the spare code): fill workers in order first,
            // then pick the least loaded, with ties going to the higher index.
            if (sched_tasks_seen < n)
            begin
                w = int'(sched_tasks_seen);
            end
            else
            begin
                w = 0;
                for (i = 1; i < n; i++)
                begin
                    if (sched_loads[i] <= sched_loads[w])
                        w = i;
                end
            end
        end

        if (sched_tasks_seen != TASK_MAX)
            sched_tasks_seen = sched_tasks_seen + 1'b1;

        // Loads saturate at the all-ones value.
        sum = {1'b0, sched_loads[w]} + (LOAD_BITS+1)'(req.duration);
        if (sum > LOAD_MAX)
            sum = LOAD_MAX;
        sched_loads[w] = sum[LOAD_BITS-1:0];
        if (sched_loads[w] > sched_peak)
            sched_peak = sched_loads[w];

        res.worker_index = IDX_BITS'(w);
        res.worker_load  = sched_loads[w];
        res.peak_load    = sched_peak;
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offers one request, optionally after a random idle burst, and records
    // the prediction on the edge where it is accepted. Valid stays high
    // across back-to-back requests; it only drops when a gap is inserted.
    task automatic send_request(input logic [DUR_BITS-1:0] dur, input logic restart_flag);
        task_req_t req;
        result_t   predicted;
        int        gap;
        req.duration = dur;
        req.restart  = restart_flag;
        gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            task_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        task_valid <= 1'b1;
        task_req   <= req;
        do
            @(posedge clk);
        while (!task_ready);
        assign_task(req, predicted);
        pending_assignments.push_back(predicted);
        items_sent++;
    endtask

    // Drops valid and waits until every predicted result has come back, so
    // the block is idle and registers may be written.
    task automatic wait_drain();
        @(negedge clk);
        task_valid <= 1'b0;
        while (pending_assignments.size() != 0)
            @(posedge clk);
    endtask

    // Register write; the copy is updated on the edge that performs it.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_MAPPING_MODE: cfg_mode    = value[MODE_BITS-1:0];
            REG_WORKER_COUNT: cfg_workers = value[COUNT_BITS-1:0];
            REG_TASK_TOTAL:   cfg_total   = value[TASK_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mix of zero, all-ones, small and full-range durations.
    function automatic logic [DUR_BITS-1:0] random_duration();
        logic [DUR_BITS-1:0] d;
        case ($urandom_range(0, 9))
            0:          d = '0;
            1:          d = '1;
            2, 3, 4, 5: d = $urandom_range(0, 1000);
            default:    d = $urandom;
        endcase
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus a long hold-off on request. Exactly
    // one assignment to result_ready per falling edge.
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result is matched against the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_assignments.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result: worker %0d load %h peak %h",
                             result.worker_index, result.worker_load, result.peak_load);
                fail_count++;
            end
            else
            begin
                want = pending_assignments.pop_front();
                if (result.worker_index !== want.worker_index ||
                    result.worker_load  !== want.worker_load  ||
                    result.peak_load    !== want.peak_load)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("mismatch: worker exp %0d got %0d, load exp %h got %h, peak exp %h got %h",
                                 want.worker_index, result.worker_index,
                                 want.worker_load, result.worker_load,
                                 want.peak_load, result.peak_load);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset defaults first (sixteen workers, dynamic), then four workers:
    // in-order fill, then least-loaded picks with ties to the higher index.
    task automatic test_dynamic_mode();
        send_request('1, 1'b0);
        send_request('0, 1'b0);
        wait_drain();
        write_register(REG_WORKER_COUNT, 16'd4);
        send_request(32'd7, 1'b1);
        send_request(32'd0, 1'b0);
        send_request(32'd7, 1'b0);
        send_request(32'd0, 1'b0);
        send_request(32'd2, 1'b0);
        send_request(32'd5, 1'b0);
        wait_drain();
    endtask

    // Round robin over three workers, then the count shrinks to two while the
    // pointer sits on worker two, which must wrap to worker zero.
    task automatic test_cyclic_mode();
        write_register(REG_MAPPING_MODE, 16'(MODE_CYCLIC));
        write_register(REG_WORKER_COUNT, 16'd3);
        send_request(32'd10, 1'b1);
        send_request(32'd20, 1'b0);
        send_request(32'd30, 1'b0);
        send_request(32'd40, 1'b0);
        send_request(32'd50, 1'b0);
        wait_drain();
        write_register(REG_WORKER_COUNT, 16'd2);
        send_request(32'd60, 1'b0);
        send_request(32'd70, 1'b0);
        wait_drain();
    endtask

    // Six tasks on four workers give blocks of 2,2,1,1 with overflow kept on
    // the last worker; two tasks on four workers leave empty blocks to skip.
    task automatic test_block_mode();
        write_register(REG_MAPPING_MODE, 16'(MODE_BLOCK));
        write_register(REG_WORKER_COUNT, 16'd4);
        write_register(REG_TASK_TOTAL, 16'd6);
        send_request(32'd1, 1'b1);
        repeat (6) send_request(random_duration(), 1'b0);
        wait_drain();
        write_register(REG_TASK_TOTAL, 16'd2);
        send_request(32'd3, 1'b1);
        send_request(32'd3, 1'b0);
        send_request(32'd3, 1'b0);
        wait_drain();
    endtask

    // Spare mode code with a zero worker count, then an oversized count and
    // the largest task total.
    task automatic test_register_extremes();
        write_register(REG_MAPPING_MODE, 16'(MODE_SPARE));
        write_register(REG_WORKER_COUNT, 16'd0);
        send_request('1, 1'b1);
        send_request(32'd9, 1'b0);
        wait_drain();
        write_register(REG_WORKER_COUNT, 16'd31);
        write_register(REG_TASK_TOTAL, 16'hFFFF);
        send_request(32'd4, 1'b0);
        send_request('1, 1'b0);
        wait_drain();
    endtask

    // One worker fed all-ones durations: the load reaches the 40-bit ceiling
    // after 257 tasks and must stay pinned there.
    task automatic test_load_saturation();
        int i;
        write_register(REG_MAPPING_MODE, 16'(MODE_DYNAMIC));
        write_register(REG_WORKER_COUNT, 16'd1);
        for (i = 0; i < 260; i++)
        begin
            send_request('1, i == 0);
        end
        wait_drain();
    endtask

    // Episodes of random configuration, each normally opened by a restart,
    // with random durations and the odd stray restart inside.
    task automatic test_random_episodes(input int item_goal);
        int start;
        int len;
        int i;
        logic [CFG_DATA_BITS-1:0] value;
        start = items_sent;
        while (items_sent - start < item_goal)
        begin
            wait_drain();
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: value = 16'(MODE_DYNAMIC);
                    3, 4, 5: value = 16'(MODE_CYCLIC);
                    6, 7, 8: value = 16'(MODE_BLOCK);
                    default: value = 16'(MODE_SPARE);
                endcase
                write_register(REG_MAPPING_MODE, value);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                value = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(1, 16));
                write_register(REG_WORKER_COUNT, value);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                value = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 80));
                write_register(REG_TASK_TOTAL, value);
            end
            len = $urandom_range(8, 60);
            for (i = 0; i < len; i++)
            begin
                if (i == 0)
                    send_request(random_duration(), $urandom_range(0, 7) != 0);
                else
                    send_request(random_duration(), $urandom_range(0, 39) == 0);
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering requests, so the block fills and stalls its input. Afterwards
    // the sender pauses until all results are back before going on.
    task automatic test_backpressure();
        int i;
        wait_drain();
        sender_idles = 1'b0;
        hold_left = LONG_HOLD;
        for (i = 0; i < 40; i++)
        begin
            send_request(random_duration(), i == 0);
        end
        sender_idles = 1'b1;
        wait_drain();
        for (i = 0; i < 10; i++)
        begin
            send_request(random_duration(), 1'b0);
        end
    endtask

    // Final stretch at full rate with no idling on either side.
    task automatic test_streaming();
        wait_drain();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        stall_left     = 0;
        test_random_episodes(200);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        cfg_mode    = MODE_DYNAMIC;
        cfg_workers = COUNT_BITS'(WORKERS);
        cfg_total   = '0;
        clear_schedule();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        test_dynamic_mode();
        test_cyclic_mode();
        test_block_mode();
        test_register_extremes();
        test_load_saturation();
        test_random_episodes(530);
        test_backpressure();
        test_random_episodes(530);
        test_streaming();

        // Everything predicted must arrive, and nothing extra may follow.
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_assignments.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
